### hw/rtl/sla_pkg.sv
// Shared types and constants for the slot allocator.
// Used by every module under hw/rtl but sla_ram; depends on nothing.
`default_nettype none

package sla_pkg;

    // Default configuration of the slot table
    localparam int SLOT_COUNT_DEF  = 1024;
    localparam int SLOT_BITS_DEF   = 10;
    localparam int START_SPAWN_DEF = 1;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Field widths of the request and result items
    localparam int TAG_W      = 32;
    localparam int SLOT_IN_W  = 11;
    localparam int OUT_SLOT_W = 10;
    localparam int SPAWN_W    = 22;
    localparam int USED_W     = 11;
    localparam int STATUS_W   = 2;

    // Request command codes
    localparam logic OP_REGISTER   = 1'b0;
    localparam logic OP_UNREGISTER = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_REGISTERED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RELEASED   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED    = 2'd3;

    // Classified request kinds handed from front to back
    typedef enum logic [1:0] {
        KIND_IGNORE,
        KIND_ALLOC,
        KIND_FREE
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [TAG_W-1:0]     tag;
        logic [SLOT_IN_W-1:0] slot;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [OUT_SLOT_W-1:0] assigned_slot;
        logic [SPAWN_W-1:0]    spawn_id;
        logic [USED_W-1:0]     used_count;
    } res_t;

endpackage

`default_nettype wire

### hw/rtl/sla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module sla_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/sla_front.sv
// Front end: accept requests, classify them and hold one in a register stage.
// Depends on sla_pkg.
`default_nettype none

module sla_front #(
    parameter int SLOT_COUNT = sla_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          enable,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          in_command,
    input  wire logic [sla_pkg::TAG_W-1:0]     in_tag,
    input  wire logic [sla_pkg::SLOT_IN_W-1:0] in_slot,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output sla_pkg::cmd_t                      push_cmd
);

    logic          valid_reg;
    logic          valid_next;
    sla_pkg::cmd_t cmd_reg;
    sla_pkg::cmd_t cmd_next;
    sla_pkg::cmd_t cls;
    logic [31:0]   slot_ext;
    logic          accept;

    assign slot_ext = 32'(in_slot);

    // Zero tags, negative slots and slots past the table end never reach the table.
    always_comb
    begin
        cls.tag  = in_tag;
        cls.slot = in_slot;
        if (in_tag == '0)
        begin
            cls.kind = sla_pkg::KIND_IGNORE;
        end
        else if (in_command == sla_pkg::OP_REGISTER)
        begin
            cls.kind = sla_pkg::KIND_ALLOC;
        end
        else if (in_slot[sla_pkg::SLOT_IN_W-1] || (slot_ext >= 32'(SLOT_COUNT)))
        begin
            cls.kind = sla_pkg::KIND_IGNORE;
        end
        else
        begin
            cls.kind = sla_pkg::KIND_FREE;
        end
    end

    assign in_ready   = enable && (!valid_reg || push_ready);
    assign accept     = in_valid && in_ready;
    assign push_valid = valid_reg;
    assign push_cmd   = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (valid_reg && push_ready)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next = 1'b1;
            cmd_next   = cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

### hw/rtl/sla_fifo.sv
// Short queue of classified requests between front and back.
// Depends on sla_pkg.
`default_nettype none

module sla_fifo #(
    parameter int DEPTH = sla_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire sla_pkg::cmd_t push_cmd,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output sla_pkg::cmd_t      pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sla_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sla_back.sv
// Back end: clear the owner table, then scan, allocate and release slots.
// Depends on sla_pkg and sla_ram.
`default_nettype none

module sla_back #(
    parameter int SLOT_COUNT        = sla_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_BITS         = sla_pkg::SLOT_BITS_DEF,
    parameter int START_SPAWN_COUNT = sla_pkg::START_SPAWN_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    output logic               init_done,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire sla_pkg::cmd_t q_cmd,
    output logic               out_valid,
    input  wire logic          out_ready,
    output sla_pkg::res_t      out_res
);

    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int HINT_W = $clog2(SLOT_COUNT + 1);
    localparam int CNT_W  = 32 - SLOT_BITS + 1;
    localparam logic [CNT_W-1:0]  SPAWN_LIMIT = {1'b1, {(CNT_W - 1){1'b0}}};
    localparam logic [CNT_W-1:0]  SPAWN_START = CNT_W'(START_SPAWN_COUNT);
    localparam logic [HINT_W-1:0] HINT_END    = HINT_W'(SLOT_COUNT);
    localparam logic [IDX_W-1:0]  IDX_LAST    = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_FREE_RD,
        ST_FREE_CHK
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    sla_pkg::cmd_t cmd_reg;
    sla_pkg::cmd_t cmd_next;
    logic [HINT_W-1:0] hint_reg;
    logic [HINT_W-1:0] hint_next;
    logic [HINT_W-1:0] hw_reg;
    logic [HINT_W-1:0] hw_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [IDX_W-1:0]  clr_reg;
    logic [IDX_W-1:0]  clr_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    sla_pkg::res_t     res_reg;
    sla_pkg::res_t     res_next;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [sla_pkg::TAG_W-1:0] ram_wdata;
    logic [IDX_W-1:0]          ram_raddr;
    logic [sla_pkg::TAG_W-1:0] ram_rdata;

    logic [31:0]       slot_ext;
    logic [IDX_W-1:0]  slot_idx;
    logic [HINT_W-1:0] slot_hint;
    logic [HINT_W-1:0] hint_inc;
    logic [31:0]       cnt_ext;
    logic              out_free;

    sla_ram #(
        .WIDTH (sla_pkg::TAG_W),
        .DEPTH (SLOT_COUNT)
    ) u_owner_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign slot_ext  = 32'(cmd_reg.slot);
    assign slot_idx  = slot_ext[IDX_W-1:0];
    assign slot_hint = HINT_W'(slot_idx);
    assign hint_inc  = hint_reg + HINT_W'(1);
    assign cnt_ext   = 32'(cnt_reg);
    assign out_free  = !out_valid_reg || out_ready;

    assign init_done = (state_reg != ST_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;
    assign ram_raddr = (state_reg == ST_FREE_RD) ? slot_idx : hint_reg[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        hint_next      = hint_reg;
        hw_next        = hw_reg;
        cnt_next       = cnt_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_waddr      = hint_reg[IDX_W-1:0];
        ram_wdata      = '0;
        q_ready        = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_ready  = 1'b1;
                    cmd_next = q_cmd;
                    case (q_cmd.kind)
                        sla_pkg::KIND_ALLOC:
                        begin
                            // Wrap the spawn counter before the scan, even if the table is full.
                            if (cnt_reg >= SPAWN_LIMIT)
                            begin
                                cnt_next = SPAWN_START;
                            end
                            if (hint_reg >= HINT_END)
                            begin
                                out_valid_next = 1'b1;
                                res_next = '{sla_pkg::STATUS_FULL, '0, '0,
                                             sla_pkg::USED_W'(hw_reg)};
                            end
                            else
                            begin
                                state_next = ST_SCAN_RD;
                            end
                        end
                        sla_pkg::KIND_FREE:
                        begin
                            state_next = ST_FREE_RD;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            res_next = '{sla_pkg::STATUS_IGNORED, '0, '0,
                                         sla_pkg::USED_W'(hw_reg)};
                        end
                    endcase
                end
            end

            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CHK;
            end

            ST_SCAN_CHK:
            begin
                hint_next = hint_inc;
                if (ram_rdata == '0)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = cmd_reg.tag;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    if (hint_reg >= hw_reg)
                    begin
                        hw_next = hw_reg + HINT_W'(1);
                    end
                    out_valid_next = 1'b1;
                    res_next = '{sla_pkg::STATUS_REGISTERED,
                                 sla_pkg::OUT_SLOT_W'(hint_reg),
                                 cnt_ext[sla_pkg::SPAWN_W-1:0],
                                 sla_pkg::USED_W'(hw_next)};
                    state_next = ST_IDLE;
                end
                else if (hint_inc >= HINT_END)
                begin
                    out_valid_next = 1'b1;
                    res_next = '{sla_pkg::STATUS_FULL, '0, '0, sla_pkg::USED_W'(hw_reg)};
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end

            ST_FREE_RD:
            begin
                state_next = ST_FREE_CHK;
            end

            ST_FREE_CHK:
            begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
                if (ram_rdata == cmd_reg.tag)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_idx;
                    if (slot_hint < hint_reg)
                    begin
                        hint_next = slot_hint;
                    end
                    res_next = '{sla_pkg::STATUS_RELEASED, '0, '0, sla_pkg::USED_W'(hw_reg)};
                end
                else
                begin
                    res_next = '{sla_pkg::STATUS_IGNORED, '0, '0, sla_pkg::USED_W'(hw_reg)};
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            hint_reg      <= '0;
            hw_reg        <= '0;
            cnt_reg       <= SPAWN_START;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            hw_reg        <= hw_next;
            cnt_reg       <= cnt_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

### hw/rtl/slot_allocator_with_spawn_ids.sv
// Slot allocator with spawn ids. An ignored request goes from the front register through
// the queue to the back end's result register; unregister adds a read and check of its
// slot; register reads and checks each slot that the scan visits (one table read and
// check per slot on the owner RAM's single read port). Throughput: one request at a
// time in the back end; the front stage and a 2-entry queue take requests ahead.
// After reset a clearing pass zeroes the owner table; no request is accepted until it ends.
// Depends on sla_pkg, sla_front, sla_fifo, sla_back and sla_ram.
`default_nettype none

module slot_allocator_with_spawn_ids #(
    parameter int SLOT_COUNT        = sla_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_BITS         = sla_pkg::SLOT_BITS_DEF,
    parameter int START_SPAWN_COUNT = sla_pkg::START_SPAWN_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // [31:0] owner_tag, [42:32] slot_index, rest 0
    input  wire logic [0:0]  s_axis_tuser,  // [0] command
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [47:0] m_axis_tdata,  // [9:0] assigned_slot, [31:10] spawn_id,
                                            // [42:32] used_count, rest 0
    output logic      [1:0]  m_axis_tuser   // [1:0] status
);

    // Front to queue
    logic          fr_valid;
    logic          fr_ready;
    sla_pkg::cmd_t fr_cmd;

    // Queue to back
    logic          q_valid;
    logic          q_ready;
    sla_pkg::cmd_t q_cmd;

    // Back status and results
    logic          init_done;
    sla_pkg::res_t res;

    // Classify requests: drop zero tags and out-of-range slots to the ignore path.
    sla_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (init_done),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_command (s_axis_tuser[0]),
        .in_tag     (s_axis_tdata[31:0]),
        .in_slot    (s_axis_tdata[42:32]),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_cmd   (fr_cmd)
    );

    // Decouple the front from the table walk.
    sla_fifo #(
        .DEPTH (sla_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_cmd   (fr_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    // Own the owner table, free hint, high-water count and spawn counter; hold the
    // result in an output register until the sink takes it.
    sla_back #(
        .SLOT_COUNT        (SLOT_COUNT),
        .SLOT_BITS         (SLOT_BITS),
        .START_SPAWN_COUNT (START_SPAWN_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .init_done (init_done),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // Pack the result fields, lowest first.
    assign m_axis_tdata = {5'b0, res.used_count, res.spawn_id, res.assigned_slot};
    assign m_axis_tuser = res.status;

endmodule

`default_nettype wire

### tb/sv/tb_slot_allocator_with_spawn_ids.sv
// Self-checking testbench for slot_allocator_with_spawn_ids: drives register and
// unregister requests on the request stream and checks every result field.
// Depends on sla_pkg and the block itself; reads no files.
module tb_slot_allocator_with_spawn_ids;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT  = sla_pkg::SLOT_COUNT_DEF;
    localparam int SPAWN_LIMIT = 1 << (32 - sla_pkg::SLOT_BITS_DEF);
    localparam int HALF_PERIOD = 6;
    localparam int TAG_W       = sla_pkg::TAG_W;
    localparam int SLOT_IN_W   = sla_pkg::SLOT_IN_W;
    localparam int STATUS_W    = sla_pkg::STATUS_W;
    localparam int OUT_SLOT_W  = sla_pkg::OUT_SLOT_W;
    localparam int SPAWN_W     = sla_pkg::SPAWN_W;
    localparam int USED_W      = sla_pkg::USED_W;

    // One result of the slot table, as the block reports it
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [OUT_SLOT_W-1:0] assigned_slot;
        logic [SPAWN_W-1:0]    spawn_id;
        logic [USED_W-1:0]     used_count;
    } alloc_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // [31:0] owner_tag, [42:32] slot_index, rest 0
    logic [0:0]  s_axis_tuser;   // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // [9:0] assigned_slot, [31:10] spawn_id, [42:32] used_count
    logic [1:0]  m_axis_tuser;   // [1:0] status

    // Shadow copy of the slot table, updated as each request is accepted
    logic [TAG_W-1:0]   owner_tab [SLOT_COUNT];
    logic [22:0]        spawn_ctr;
    int                 free_hint;
    int                 high_water;
    logic [STATUS_W-1:0] last_status;

    alloc_result_t pending_results[$];

    int n_requests;
    int n_results;
    int n_errors;
    int status_seen [4];

    // Stimulus controls shared by the sender, the sink and the tests
    bit burst_mode;
    int hold_left;
    int sink_wait;
    bit result_taken;

    slot_allocator_with_spawn_ids i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: apply one request to the shadow table and return the
    // result the block must produce for it.
    // ------------------------------------------------------------------
    function automatic alloc_result_t allocate_or_release(
        input logic                        cmd,
        input logic [TAG_W-1:0]            tag,
        input logic signed [SLOT_IN_W-1:0] slot
    );
        alloc_result_t r;
        int            got;
        r = '0;
        r.status = sla_pkg::STATUS_IGNORED;
        if (tag == '0)
        begin
            // Zero tag: ignored for either command, nothing changes
            r.status = sla_pkg::STATUS_IGNORED;
        end
        else if (cmd == sla_pkg::OP_REGISTER)
        begin
            // Wrap the spawn counter before use, even if the table turns out full
            if (spawn_ctr >= SPAWN_LIMIT)
                spawn_ctr = 23'(sla_pkg::START_SPAWN_DEF);
            while (free_hint < SLOT_COUNT && owner_tab[free_hint] != '0)
                free_hint++;
            if (free_hint >= SLOT_COUNT)
            begin
                r.status = sla_pkg::STATUS_FULL;
            end
            else
            begin
                got = free_hint;
                free_hint++;
                owner_tab[got] = tag;
                r.status        = sla_pkg::STATUS_REGISTERED;
                r.assigned_slot = got[OUT_SLOT_W-1:0];
                r.spawn_id      = spawn_ctr[SPAWN_W-1:0];
                spawn_ctr++;
                if (got >= high_water)
                    high_water++;
            end
        end
        else if (slot < 0 || slot >= SLOT_COUNT)
        begin
            // Never registered (minus one) or out of range
            r.status = sla_pkg::STATUS_IGNORED;
        end
        else if (owner_tab[slot] != tag)
        begin
            r.status = sla_pkg::STATUS_IGNORED;
        end
        else
        begin
            owner_tab[slot] = '0;
            if (slot < free_hint)
                free_hint = slot;
            r.status = sla_pkg::STATUS_RELEASED;
        end
        r.used_count = high_water[USED_W-1:0];
        last_status  = r.status;
        status_seen[r.status]++;
        return r;
    endfunction

    // Pick an occupied slot at random; -1 when none is found quickly
    function automatic int pick_live_slot();
        int idx;
        for (int k = 0; k < 48; k++)
        begin
            idx = $urandom_range(0, SLOT_COUNT - 1);
            if (owner_tab[idx] != '0)
                return idx;
        end
        return -1;
    endfunction

    function automatic logic [TAG_W-1:0] random_tag();
        logic [TAG_W-1:0] t;
        t = $urandom();
        if (t == '0)
            t = 32'h1;
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer one request, wait for the handshake, record the
    // expected result. Leaves tvalid high so back-to-back requests flow
    // without a bubble; callers that pause drop it through drain_results.
    // ------------------------------------------------------------------
    task automatic send_request(
        input logic                        cmd,
        input logic [TAG_W-1:0]            tag,
        input logic signed [SLOT_IN_W-1:0] slot
    );
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = {5'b0, slot, tag};
        s_axis_tuser  = cmd;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(allocate_or_release(cmd, tag, slot));
        n_requests++;
        @(negedge clk);
    endtask

    // Hold the request side quiet until every expected result has arrived
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        @(negedge clk);
    endtask

    // Release a live slot with its own tag, or register when no live slot is found quickly
    task automatic release_live();
        int s;
        s = pick_live_slot();
        if (s < 0)
            send_request(sla_pkg::OP_REGISTER, random_tag(), SLOT_IN_W'($urandom()));
        else
            send_request(sla_pkg::OP_UNREGISTER, owner_tab[s], SLOT_IN_W'(s));
    endtask

    // Malformed or pointless requests of every kind
    task automatic send_noise();
        int s;
        case ($urandom_range(0, 6))
            0: send_request(sla_pkg::OP_REGISTER, '0, SLOT_IN_W'($urandom()));
            1: send_request(sla_pkg::OP_UNREGISTER, '0,
                            SLOT_IN_W'($urandom_range(0, SLOT_COUNT - 1)));
            2: send_request(sla_pkg::OP_UNREGISTER, random_tag(), SLOT_IN_W'(-1));
            3: send_request(sla_pkg::OP_UNREGISTER, random_tag(), {1'b1, 10'($urandom())});
            4:
            begin
                // Tag mismatch on an occupied slot: flip one bit of the owner
                s = pick_live_slot();
                if (s < 0)
                    send_request(sla_pkg::OP_UNREGISTER, random_tag(), SLOT_IN_W'(0));
                else
                    send_request(sla_pkg::OP_UNREGISTER,
                                 owner_tab[s] ^ (32'h1 << $urandom_range(0, 31)),
                                 SLOT_IN_W'(s));
            end
            default: send_request(sla_pkg::OP_UNREGISTER, random_tag(),
                                  SLOT_IN_W'($urandom_range(0, SLOT_COUNT - 1)));
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every command and each corner case once
    task automatic test_directed();
        send_request(sla_pkg::OP_REGISTER,   32'hFFFF_FFFF, 11'd0);
        send_request(sla_pkg::OP_REGISTER,   32'h0000_0001, 11'h7FF);   // slot_index unused
        send_request(sla_pkg::OP_REGISTER,   32'h0,         11'd0);     // zero tag
        send_request(sla_pkg::OP_UNREGISTER, 32'h0,         11'd0);     // zero tag
        send_request(sla_pkg::OP_UNREGISTER, 32'h0000_0005, 11'h7FF);   // never registered
        send_request(sla_pkg::OP_UNREGISTER, 32'h0000_0001, 11'h400);   // most negative
        send_request(sla_pkg::OP_UNREGISTER, 32'h0000_0001, 11'h7FE);   // out of range
        send_request(sla_pkg::OP_UNREGISTER, 32'h0000_0002, 11'd1);     // tag mismatch
        send_request(sla_pkg::OP_UNREGISTER, 32'h0000_0001, 11'd1023);  // empty, top index
        send_request(sla_pkg::OP_UNREGISTER, 32'hFFFF_FFFF, 11'd0);     // release lowers hint
        send_request(sla_pkg::OP_REGISTER,   32'hA5A5_5A5A, 11'h2AA);
        send_request(sla_pkg::OP_REGISTER,   32'h8000_0000, 11'd1023);
        send_request(sla_pkg::OP_UNREGISTER, 32'h0000_0001, 11'd1);
        send_request(sla_pkg::OP_UNREGISTER, 32'h0000_0001, 11'd1);     // already empty
        send_request(sla_pkg::OP_REGISTER,   32'h5A5A_A5A5, 11'd0);
        // Sender pause: wait for every result before moving on
        drain_results();
    endtask

    // Register until the table is full, then probe full and the longest scan
    task automatic test_fill_to_full();
        int full_hits;
        full_hits  = 0;
        burst_mode = 1'b1;
        while (full_hits < 2)
        begin
            if (high_water > SLOT_COUNT / 2)
                burst_mode = 1'b0;
            send_request(sla_pkg::OP_REGISTER, random_tag(), SLOT_IN_W'($urandom()));
            if (last_status == sla_pkg::STATUS_FULL)
                full_hits++;
        end
        // Free the two ends; the second register then scans from slot 1 up to the last slot
        send_request(sla_pkg::OP_UNREGISTER, owner_tab[SLOT_COUNT - 1],
                     SLOT_IN_W'(SLOT_COUNT - 1));
        send_request(sla_pkg::OP_UNREGISTER, owner_tab[0], SLOT_IN_W'(0));
        send_request(sla_pkg::OP_REGISTER, random_tag(), SLOT_IN_W'(0));
        send_request(sla_pkg::OP_REGISTER, random_tag(), SLOT_IN_W'(0));
        send_request(sla_pkg::OP_REGISTER, random_tag(), SLOT_IN_W'(0));
        drain_results();
    endtask

    // Empty a large part of the table in random order, with some noise
    task automatic test_release_many();
        repeat (400)
        begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                release_live();
        end
        drain_results();
    endtask

    // Hold off the result side while requests keep coming, so the block
    // backs up and drops its tready
    task automatic test_backpressure();
        hold_left  = 300;
        burst_mode = 1'b1;
        repeat (6)
        begin
            release_live();
            send_request(sla_pkg::OP_REGISTER, random_tag(), SLOT_IN_W'($urandom()));
        end
        burst_mode = 1'b0;
        drain_results();
    endtask

    // Mostly well-formed register/release traffic with random content
    task automatic test_random_mix();
        int pick;
        for (int n = 0; n < 360; n++)
        begin
            // Toggle short stretches without any idling
            burst_mode = ((n / 40) % 3 == 1);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_request(sla_pkg::OP_REGISTER, random_tag(), SLOT_IN_W'($urandom()));
            else if (pick < 78)
                release_live();
            else
                send_noise();
        end
        burst_mode = 1'b0;
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Result sink: outside burst mode, drop tready for a random wait after each result,
    // plus any long hold-off that a test requests.
    // ------------------------------------------------------------------
    initial
    begin
        m_axis_tready = 1'b0;
        sink_wait     = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (result_taken)
            begin
                result_taken = 1'b0;
                sink_wait    = burst_mode ? 0 : $urandom_range(0, 5);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready = 1'b0;
            end
            else if (sink_wait > 0)
            begin
                sink_wait--;
                m_axis_tready = 1'b0;
            end
            else
            begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each accepted result with the oldest expectation
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch on result %0d, expected %0d, actual %0d",
                     $time, name, n_results, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            result_taken = 1'b1;
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual status %0d data %h",
                         $time, m_axis_tuser, m_axis_tdata);
                n_errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", longint'(want.status), longint'(m_axis_tuser));
                check_field("assigned_slot", longint'(want.assigned_slot),
                            longint'(m_axis_tdata[9:0]));
                check_field("spawn_id", longint'(want.spawn_id),
                            longint'(m_axis_tdata[31:10]));
                check_field("used_count", longint'(want.used_count),
                            longint'(m_axis_tdata[42:32]));
                check_field("pad bits", 64'sd0, longint'(m_axis_tdata[47:43]));
            end
            n_results++;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        rst_n         = 1'b0;
        burst_mode    = 1'b0;
        hold_left     = 0;
        result_taken  = 1'b0;
        n_requests    = 0;
        n_results     = 0;
        n_errors      = 0;
        status_seen   = '{default: 0};
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            owner_tab[i] = '0;
        end
        spawn_ctr  = 23'(sla_pkg::START_SPAWN_DEF);
        free_hint  = 0;
        high_water = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The block clears its table after reset; the sender simply waits
        // on tready, so no fixed delay is needed here.
        test_directed();
        test_fill_to_full();
        test_release_many();
        test_backpressure();
        test_random_mix();

        drain_results();
        repeat (40) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            $display("%0t ns: %0d expected results never arrived", $time,
                     pending_results.size());
            n_errors++;
        end

        $display("Covered %0d requests, %0d results checked, %0d errors", n_requests,
                 n_results, n_errors);
        $display("Statuses: %0d registered, %0d full, %0d released, %0d ignored",
                 status_seen[sla_pkg::STATUS_REGISTERED], status_seen[sla_pkg::STATUS_FULL],
                 status_seen[sla_pkg::STATUS_RELEASED], status_seen[sla_pkg::STATUS_IGNORED]);
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, every register scanning
    // the whole table behind the longest stalls and gaps
    initial
    begin
        #200_000_000;
        $display("%0t ns: timeout with %0d results outstanding", $time,
                 pending_results.size());
        $display("Verification failed");
        $finish;
    end

endmodule

### files.f
hw/rtl/sla_pkg.sv
hw/rtl/sla_ram.sv
hw/rtl/sla_front.sv
hw/rtl/sla_fifo.sv
hw/rtl/sla_back.sv
hw/rtl/slot_allocator_with_spawn_ids.sv
tb/sv/tb_slot_allocator_with_spawn_ids.sv
